[rtl/bavz_pkg.sv]
`default_nettype none

package bavz_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned MAG_W      = 23;
  localparam int unsigned RECIP_W    = 24;
  localparam int unsigned MEAN_W     = 17;
  localparam int unsigned MG_W       = 16;
  localparam int unsigned MGP_W      = 31;
  localparam int unsigned MG_NUM     = 4050;
  localparam int unsigned MG_SHIFT   = 10;
  localparam int unsigned NUM_STAGES = 4;
  localparam int unsigned NUM_LANES  = 3;

  typedef struct packed {
    logic                  accept;
    logic                  last;
    logic                  capture;
    logic [NUM_STAGES-1:0] ld;
  } lane_ctrl_t;

endpackage

`default_nettype wire

[rtl/bavz_lane.sv]
`default_nettype none

module bavz_lane #(
  parameter int unsigned SAMPLES_PER_BLOCK = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bavz_pkg::lane_ctrl_t       ctrl_i,
  input  wire logic signed [15:0]         sample_i,
  output logic signed [16:0]              mean_o,
  output logic signed [15:0]              mg_o
);

  localparam int unsigned SumW   = bavz_pkg::SUM_W;
  localparam int unsigned MagW   = bavz_pkg::MAG_W;
  localparam int unsigned RecipW = bavz_pkg::RECIP_W;
  localparam int unsigned MeanW  = bavz_pkg::MEAN_W;
  localparam int unsigned MgW    = bavz_pkg::MG_W;
  localparam int unsigned MgpW   = bavz_pkg::MGP_W;
  localparam int unsigned ProdW  = MagW + RecipW;
  localparam int unsigned QW     = MagW + 1;

  // Division by the block length is a multiply by a rounded-up reciprocal,
  // which is exact for every magnitude below two to the power MagW.
  localparam int unsigned DivL   = $clog2(SAMPLES_PER_BLOCK);
  localparam int unsigned DivS   = MagW + DivL;
  localparam logic [63:0] DivM64 =
    ((64'd1 << DivS) + 64'(SAMPLES_PER_BLOCK) - 64'd1) / 64'(SAMPLES_PER_BLOCK);
  localparam logic [RecipW-1:0] DivM = DivM64[RecipW-1:0];

  localparam logic signed [MgpW-1:0] MgNum   = MgpW'(bavz_pkg::MG_NUM);
  localparam logic signed [MgpW-1:0] MgRound = MgpW'((1 << bavz_pkg::MG_SHIFT) - 1);
  localparam logic signed [MgpW-1:0] MgMax   = MgpW'(32767);
  localparam logic signed [MgpW-1:0] MgMin   = -MgpW'(32768);

  logic signed [SumW-1:0]  sum_q, sum_d;
  logic signed [15:0]      offset_q, offset_d;
  logic signed [SumW-1:0]  tot1_q;
  logic signed [15:0]      off1_q, off2_q;
  logic                    neg2_q;
  logic [ProdW-1:0]        prod2_q;
  logic [SumW-1:0]         mag1;
  logic [ProdW-1:0]        quo_sh;
  logic [MagW-1:0]         quo;
  logic signed [QW-1:0]    quo_s;
  logic signed [QW-1:0]    diff;
  logic signed [MeanW-1:0] mean3_q, mean3_d;
  logic signed [MeanW-1:0] mean4_q;
  logic signed [MgpW-1:0]  mgp4_q;
  logic signed [MgpW-1:0]  mg_adj;
  logic signed [MgpW-1:0]  mg_sh;

  assign sum_d    = sum_q + SumW'(sample_i);
  assign offset_d = (ctrl_i.accept && ctrl_i.capture) ? sample_i : offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      offset_q <= '0;
    end else if (ctrl_i.accept) begin
      sum_q    <= ctrl_i.last ? '0 : sum_d;
      offset_q <= offset_d;
    end
  end

  assign mag1 = tot1_q[SumW-1] ? -tot1_q : tot1_q;

  always_comb begin
    quo_sh  = prod2_q >> DivS;
    quo     = quo_sh[MagW-1:0];
    quo_s   = neg2_q ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    diff    = quo_s - QW'(off2_q);
    mean3_d = diff[MeanW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld[0]) begin
      tot1_q <= sum_d;
      off1_q <= offset_d;
    end
    if (ctrl_i.ld[1]) begin
      neg2_q  <= tot1_q[SumW-1];
      prod2_q <= ProdW'(mag1[MagW-1:0]) * ProdW'(DivM);
      off2_q  <= off1_q;
    end
    if (ctrl_i.ld[2]) begin
      mean3_q <= mean3_d;
    end
    if (ctrl_i.ld[3]) begin
      mean4_q <= mean3_q;
      mgp4_q  <= MgpW'(mean3_q) * MgNum;
    end
  end

  // The shift rounds toward zero once negative products are biased up.
  always_comb begin
    mg_adj = mgp4_q + (mgp4_q[MgpW-1] ? MgRound : '0);
    mg_sh  = mg_adj >>> bavz_pkg::MG_SHIFT;
    if (mg_sh > MgMax) begin
      mg_o = MgMax[MgW-1:0];
    end else if (mg_sh < MgMin) begin
      mg_o = MgMin[MgW-1:0];
    end else begin
      mg_o = mg_sh[MgW-1:0];
    end
  end

  assign mean_o = mean4_q;

endmodule

`default_nettype wire

[rtl/three_axis_block_average_zero.sv]
// Each block's result goes through the stage registers and the output register.
// Throughput: one word per cycle when not stalled; one result per SAMPLES_PER_BLOCK words.
// The per-channel accumulator sets the rate, adding one sample in each cycle that accepts.
// Reset (rst_ni low, asynchronous) clears the sums, the sample count, the zero offsets,
// the pending zero request and all valid flags.
`default_nettype none

module three_axis_block_average_zero #(
  parameter int unsigned SAMPLES_PER_BLOCK = 10
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // sample_a [15:0], sample_b [31:16], sample_c [47:32]
  input  wire logic [47:0]  s_axis_tdata,
  // zero_request [0]
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // mean_a [16:0], mean_b [33:17], mean_c [50:34], milligauss_a [66:51],
  // milligauss_b [82:67], milligauss_c [98:83], zero padding [103:99]
  output logic [103:0]      m_axis_tdata,
  // zero_taken [0]
  output logic              m_axis_tuser
);

  localparam int unsigned CntW    = $clog2(SAMPLES_PER_BLOCK + 1);
  localparam int unsigned Stages  = bavz_pkg::NUM_STAGES;
  localparam int unsigned Lanes   = bavz_pkg::NUM_LANES;
  localparam int unsigned SampleW = bavz_pkg::SAMPLE_W;
  localparam int unsigned MeanW   = bavz_pkg::MEAN_W;
  localparam int unsigned MgW     = bavz_pkg::MG_W;
  localparam logic [CntW-1:0] LastCnt = CntW'(SAMPLES_PER_BLOCK - 1);

  logic [CntW-1:0]   count_q;
  logic              pending_q;
  logic [Stages-1:0] v_q;
  logic [Stages-1:0] tk_q;
  logic [Stages-1:0] ld;
  logic              ld_out;
  logic              out_v_q;
  logic              out_tk_q;
  logic              accept;
  logic              last;
  logic              capture;

  logic signed [MeanW-1:0] mean_w [Lanes];
  logic signed [MgW-1:0]   mg_w   [Lanes];
  logic signed [MeanW-1:0] mean_q [Lanes];
  logic signed [MgW-1:0]   mg_q   [Lanes];

  bavz_pkg::lane_ctrl_t ctrl;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign last    = (count_q == LastCnt);
  assign capture = pending_q || s_axis_tuser;

  always_comb begin
    ld_out           = !out_v_q || m_axis_tready;
    ld[Stages-1]     = !v_q[Stages-1] || ld_out;
    for (int k = Stages - 2; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  assign s_axis_tready = ld[0];

  assign ctrl.accept  = accept;
  assign ctrl.last    = last;
  assign ctrl.capture = capture;
  assign ctrl.ld      = ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      pending_q <= 1'b0;
      v_q       <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= last ? '0 : count_q + 1'b1;
        pending_q <= last ? 1'b0 : capture;
      end
      if (ld[0]) begin
        v_q[0] <= accept && last;
      end
      for (int k = 1; k < Stages; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (ld_out) begin
        out_v_q <= v_q[Stages-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      tk_q[0] <= capture;
    end
    for (int k = 1; k < Stages; k++) begin
      if (ld[k]) begin
        tk_q[k] <= tk_q[k-1];
      end
    end
    if (ld_out) begin
      out_tk_q <= tk_q[Stages-1];
      for (int l = 0; l < Lanes; l++) begin
        mean_q[l] <= mean_w[l];
        mg_q[l]   <= mg_w[l];
      end
    end
  end

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    bavz_lane #(
      .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .sample_i(s_axis_tdata[g*SampleW +: SampleW]),
      .mean_o  (mean_w[g]),
      .mg_o    (mg_w[g])
    );
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_tk_q;
  assign m_axis_tdata  = {5'b0, mg_q[2], mg_q[1], mg_q[0], mean_q[2], mean_q[1], mean_q[0]};

endmodule

`default_nettype wire

[rtl/bavz_checker.sv]
`default_nettype none

module bavz_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid_i,
  input wire logic         m_axis_tready_i,
  input wire logic [103:0] m_axis_tdata_i,
  input wire logic         m_axis_tuser_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("result word changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tdata_i[103:99] == 5'b0)
    else $error("padding bits of result word not zero");

  a_mg_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tdata_i[66] |-> m_axis_tdata_i[16])
    else $error("negative milligauss from non-negative mean");

  a_mg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tdata_i[50:34] == 17'd0 |-> m_axis_tdata_i[98:83] == 16'd0)
    else $error("non-zero milligauss from zero mean");

endmodule

bind three_axis_block_average_zero bavz_checker u_bavz_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_i(m_axis_tvalid),
  .m_axis_tready_i(m_axis_tready),
  .m_axis_tdata_i (m_axis_tdata),
  .m_axis_tuser_i (m_axis_tuser)
);

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLES_PER_BLOCK = 10;
  localparam int MILLIGAUSS_NUM    = 4050;
  localparam int MILLIGAUSS_DEN    = 1024;
  localparam int RANDOM_WORDS      = 1030;
  localparam int CYCLE_LIMIT       = 200000;
  localparam int MAX_PRINTED       = 40;

  typedef struct packed {
    logic               zero_request;
    logic signed [15:0] sample_c;
    logic signed [15:0] sample_b;
    logic signed [15:0] sample_a;
  } sample_word_t;

  typedef struct packed {
    logic               zero_taken;
    logic signed [15:0] milligauss_c;
    logic signed [15:0] milligauss_b;
    logic signed [15:0] milligauss_a;
    logic signed [16:0] mean_c;
    logic signed [16:0] mean_b;
    logic signed [16:0] mean_a;
  } block_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tuser;

  sample_word_t  pending_words[$];
  block_result_t expected_blocks[$];
  sample_word_t  next_word;

  int run_sum[3];
  int zero_offset[3];
  int samples_in_block;
  bit capture_pending;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int words_accepted = 0;
  int blocks_checked = 0;
  int captures_checked = 0;

  three_axis_block_average_zero #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [15:0] to_milligauss(input int mean);
    int mg;
    mg = (mean * MILLIGAUSS_NUM) / MILLIGAUSS_DEN;
    if (mg > 32767) mg = 32767;
    if (mg < -32768) mg = -32768;
    return mg[15:0];
  endfunction

  task automatic accumulate_sample(input sample_word_t w);
    int            chan[3];
    int            mean[3];
    block_result_t r;
    chan[0] = w.sample_a;
    chan[1] = w.sample_b;
    chan[2] = w.sample_c;
    if (w.zero_request) capture_pending = 1'b1;
    for (int i = 0; i < 3; i++) run_sum[i] += chan[i];
    samples_in_block++;
    if (samples_in_block < SAMPLES_PER_BLOCK) return;
    r.zero_taken = capture_pending;
    if (capture_pending) begin
      for (int i = 0; i < 3; i++) zero_offset[i] = chan[i];
      capture_pending = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      mean[i] = run_sum[i] / SAMPLES_PER_BLOCK - zero_offset[i];
      run_sum[i] = 0;
    end
    samples_in_block = 0;
    r.mean_a = mean[0][16:0];
    r.mean_b = mean[1][16:0];
    r.mean_c = mean[2][16:0];
    r.milligauss_a = to_milligauss(mean[0]);
    r.milligauss_b = to_milligauss(mean[1]);
    r.milligauss_c = to_milligauss(mean[2]);
    expected_blocks.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at %0t, block %0d: %s", $realtime, blocks_checked, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic queue_word(input int a, input int b, input int c, input bit req);
    sample_word_t w;
    w.sample_a = a[15:0];
    w.sample_b = b[15:0];
    w.sample_c = c[15:0];
    w.zero_request = req;
    pending_words.push_back(w);
  endtask

  function automatic int pick_sample();
    case ($urandom_range(7))
      0: return 32767;
      1: return -32768;
      2: return int'($urandom_range(40)) - 20;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_word = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {next_word.sample_c, next_word.sample_b, next_word.sample_a};
        s_axis_tuser <= next_word.zero_request;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    block_result_t got;
    block_result_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      accumulate_sample(sample_word_t'({s_axis_tuser, s_axis_tdata}));
      words_accepted++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = block_result_t'({m_axis_tuser, m_axis_tdata[98:0]});
      if (expected_blocks.size() == 0) begin
        report_mismatch("result word with no block pending");
      end else begin
        want = expected_blocks.pop_front();
        check_field("mean_a", got.mean_a, want.mean_a);
        check_field("mean_b", got.mean_b, want.mean_b);
        check_field("mean_c", got.mean_c, want.mean_c);
        check_field("milligauss_a", got.milligauss_a, want.milligauss_a);
        check_field("milligauss_b", got.milligauss_b, want.milligauss_b);
        check_field("milligauss_c", got.milligauss_c, want.milligauss_c);
        check_field("zero_taken", got.zero_taken, want.zero_taken);
        check_field("padding", int'(m_axis_tdata[103:99]), 0);
        if (want.zero_taken) captures_checked++;
      end
      blocks_checked++;
    end
  end

  initial begin
    int per_phase;
    int idle_pct[3];
    int stall_pct[3];
    idle_pct = '{10, 87, 0};
    stall_pct = '{87, 10, 0};
    per_phase = RANDOM_WORDS / 3;
    for (int i = 0; i < 3; i++) begin
      run_sum[i] = 0;
      zero_offset[i] = 0;
    end
    samples_in_block = 0;
    capture_pending = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk_i);
      sender_idle_pct = idle_pct[phase];
      receiver_stall_pct = stall_pct[phase];
      if (phase == 0) begin
        // Repeated requests, one of them on the completing word: offsets become the last word.
        for (int k = 0; k < SAMPLES_PER_BLOCK; k++)
          queue_word(-32768, 32767, 0, k == 2 || k == 4 || k == SAMPLES_PER_BLOCK - 1);
        // Full-scale swing against those offsets saturates the milligauss outputs both ways,
        // and a small negative sum checks truncation toward zero.
        for (int k = 0; k < SAMPLES_PER_BLOCK; k++)
          queue_word(32767, -32768, k < 3 ? -5 : 0, 1'b0);
      end
      for (int k = 0; k < (phase == 2 ? RANDOM_WORDS - 2 * per_phase : per_phase); k++)
        queue_word(pick_sample(), pick_sample(), pick_sample(), $urandom_range(5) == 0);
      while (pending_words.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    end

    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d sample words and %0d averaged blocks, %0d with a new zero offset,",
             words_accepted, blocks_checked, captures_checked);
    $display("under sender gaps, receiver stalls and a final stretch at full rate");
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
